>>> hw/rtl/rsps_pkg.sv
// Shared types and constants of the ray/sphere pixel shader.
// No dependencies; ray_sphere_pixel_shader_top refers to it by scoped names.
`default_nettype none
package rsps_pkg;

  // Configuration register indexes (byte address = 8 * index)
  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_LIGHT0   = 3'd4,
    REG_LIGHT1   = 3'd5
  } rsps_reg_t;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  localparam logic [15:0] RST_CENTER_X = 16'd250;
  localparam logic [15:0] RST_CENTER_Y = 16'd250;
  localparam logic [15:0] RST_CENTER_Z = 16'd50;
  localparam logic [11:0] RST_RADIUS   = 12'd80;
  localparam logic [47:0] RST_LIGHT0   = 48'hFF9C_0000_0000;
  localparam logic [47:0] RST_LIGHT1   = 48'h0000_00C8_01F4;

  // Radicand widths of the two square-root pipelines, one root bit per stage
  localparam int unsigned H_SQ_W     = 32;
  localparam int unsigned H_SQ_STEPS = H_SQ_W / 2;
  localparam int unsigned L_SQ_W     = 42;
  localparam int unsigned L_SQ_STEPS = L_SQ_W / 2;

  // Cosine divider: remainder width and quotient bits below the Q1.15 overflow
  localparam int unsigned DIV_RW    = 37;
  localparam int unsigned DIV_STEPS = 15;

  localparam int unsigned PIPE_LAT =
    3 + H_SQ_STEPS + 3 + L_SQ_STEPS + 2 + DIV_STEPS + 2;

  typedef struct packed {
    logic ovf;
    logic zero;
    logic neg;
  } rsps_cos_flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/rsps_in_if.sv
// Pixel input channel: valid/ready handshake with the pixel coordinate.
// Depends on nothing.
`default_nettype none
interface rsps_in_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source(output valid, output pixel_x, output pixel_y, input ready);
  modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rsps_out_if.sv
// Shaded pixel result channel: valid/ready handshake with depth and color.
// Depends on nothing.
`default_nettype none
interface rsps_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [15:0] hit_depth;
  logic        [7:0]  red_level;
  logic        [7:0]  green_level;
  logic        [7:0]  blue_level;

  modport source(output valid, output hit, output hit_depth, output red_level,
                 output green_level, output blue_level, input ready);
  modport sink(input valid, input hit, input hit_depth, input red_level,
               input green_level, input blue_level, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rsps_delay.sv
// Enabled shift-register delay line that keeps side data aligned with the
// pipelined arithmetic units. No dependencies.
`default_nettype none
module rsps_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];
endmodule
`default_nettype wire

>>> hw/rtl/rsps_isqrt.sv
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
// No dependencies.
`default_nettype none
module rsps_isqrt #(
  parameter int W = 42
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [W-1:0]   rad,
  output logic      [W/2-1:0] root
);
  localparam int STEPS = W / 2;

  logic [W-1:0] n_r   [STEPS];
  logic [W-1:0] res_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [W-1:0] ONE_BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
    logic [W-1:0] n_in, res_in, n_nxt, res_nxt;
    logic [W:0]   trial;

    if (k == 0) begin : g_first
      assign n_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial = {1'b0, res_in} + {1'b0, ONE_BIT};
      if ({1'b0, n_in} >= trial) begin
        n_nxt   = n_in - trial[W-1:0];
        res_nxt = (res_in >> 1) + ONE_BIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[STEPS-1][W/2-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/rsps_div.sv
// Pipelined restoring divider for the Q1.15 cosine: quotient of
// (rem_in * 2^QW) / den_in with rem_in < den_in, one bit per stage.
`default_nettype none
module rsps_div #(
  parameter int RW = 37,
  parameter int QW = 15
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_in,
  input  wire logic [RW-1:0] den_in,
  output logic      [QW-1:0] quo
);
  logic [RW-1:0] rem_r [QW];
  logic [RW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] rem_prev, den_prev, rem_nxt;
    logic [QW-1:0] q_prev, q_nxt;
    logic [RW:0]   rem2;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_prev = rem_in;
      assign den_prev = den_in;
      assign q_prev   = '0;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign den_prev = den_r[k-1];
      assign q_prev   = q_r[k-1];
    end

    always_comb begin
      rem2 = {rem_prev, 1'b0};
      ge   = rem2 >= {1'b0, den_prev};
      if (ge) begin
        rem_nxt = RW'(rem2 - {1'b0, den_prev});
      end else begin
        rem_nxt = rem2[RW-1:0];
      end
      q_nxt = {q_prev[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_prev;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[QW-1];
endmodule
`default_nettype wire

>>> hw/rtl/ray_sphere_pixel_shader_top.sv
// Ray/sphere pixel shader: one pixel (x, y) per transfer in, one shaded result
// per pixel out, in order. The block takes a new pixel every cycle while the
// output is not stalled; the pipeline depth is set by the 16-step hit-depth
// square root, the 21-step vector-length square roots and the 15-step cosine
// dividers, one bit per stage. The whole pipeline holds when a
// finished result is not taken. Registers are written through the APB port at
// byte address 8*index; write them only while no pixel is in flight.
// Depends on rsps_pkg, rsps_in_if, rsps_out_if, rsps_delay, rsps_isqrt, rsps_div.
`default_nettype none
module ray_sphere_pixel_shader_top #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rsps_in_if.sink                          in_ch,
  rsps_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rsps_pkg::APB_AW-1:0] paddr,
  input  wire logic [rsps_pkg::APB_DW-1:0] pwdata,
  output logic      [rsps_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  localparam int LAT = rsps_pkg::PIPE_LAT;
  localparam int CW  = COORD_BITS;

  // ---------------- configuration ----------------
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic        [11:0] rad_r;
  logic        [47:0] lp_r [2];
  logic               wr_en;
  rsps_pkg::rsps_reg_t widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = rsps_pkg::rsps_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= rsps_pkg::RST_CENTER_X;
      cy_r    <= rsps_pkg::RST_CENTER_Y;
      cz_r    <= rsps_pkg::RST_CENTER_Z;
      rad_r   <= rsps_pkg::RST_RADIUS;
      lp_r[0] <= rsps_pkg::RST_LIGHT0;
      lp_r[1] <= rsps_pkg::RST_LIGHT1;
    end else if (wr_en) begin
      case (widx)
        rsps_pkg::REG_CENTER_X: cx_r    <= pwdata[15:0];
        rsps_pkg::REG_CENTER_Y: cy_r    <= pwdata[15:0];
        rsps_pkg::REG_CENTER_Z: cz_r    <= pwdata[15:0];
        rsps_pkg::REG_RADIUS:   rad_r   <= pwdata[11:0];
        rsps_pkg::REG_LIGHT0:   lp_r[0] <= pwdata[47:0];
        rsps_pkg::REG_LIGHT1:   lp_r[1] <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      rsps_pkg::REG_CENTER_X: prdata = {48'd0, cx_r};
      rsps_pkg::REG_CENTER_Y: prdata = {48'd0, cy_r};
      rsps_pkg::REG_CENTER_Z: prdata = {48'd0, cz_r};
      rsps_pkg::REG_RADIUS:   prdata = {52'd0, rad_r};
      rsps_pkg::REG_LIGHT0:   prdata = {16'd0, lp_r[0]};
      rsps_pkg::REG_LIGHT1:   prdata = {16'd0, lp_r[1]};
      default:                prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [LAT-1:0] vld_r, vld_nxt;
  logic           en;

  assign en          = out_ch.ready || !vld_r[LAT-1];
  assign in_ch.ready = en;
  assign vld_nxt     = {vld_r[LAT-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- A: offsets from the center ----------------
  logic        [CW-1:0] a_px_r, a_py_r;
  logic signed [16:0]   a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r <= in_ch.pixel_x;
      a_py_r <= in_ch.pixel_y;
      a_dx_r <= $signed({{(17-CW){1'b0}}, in_ch.pixel_x}) - 17'(cx_r);
      a_dy_r <= $signed({{(17-CW){1'b0}}, in_ch.pixel_y}) - 17'(cy_r);
    end
  end

  // ---------------- B: squares ----------------
  logic signed [33:0]   b_dx2_f, b_dy2_f;
  logic        [31:0]   b_dx2_r, b_dy2_r;
  logic        [23:0]   b_rr_r;
  logic        [CW-1:0] b_px_r, b_py_r;
  logic signed [16:0]   b_dx_r, b_dy_r;

  always_comb begin
    b_dx2_f = 34'(a_dx_r) * 34'(a_dx_r);
    b_dy2_f = 34'(a_dy_r) * 34'(a_dy_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dx2_r <= b_dx2_f[31:0];
      b_dy2_r <= b_dy2_f[31:0];
      b_rr_r  <= {12'd0, rad_r} * {12'd0, rad_r};
      b_px_r  <= a_px_r;
      b_py_r  <= a_py_r;
      b_dx_r  <= a_dx_r;
      b_dy_r  <= a_dy_r;
    end
  end

  // ---------------- C: discriminant ----------------
  logic signed [33:0]   c_h_f;
  logic                 c_hit_r;
  logic        [31:0]   c_sqin_r;
  logic        [CW-1:0] c_px_r, c_py_r;
  logic signed [16:0]   c_dx_r, c_dy_r;

  assign c_h_f = $signed({10'd0, b_rr_r}) - $signed({2'b0, b_dx2_r})
               - $signed({2'b0, b_dy2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      c_hit_r  <= !c_h_f[33];
      c_sqin_r <= c_h_f[33] ? 32'd0 : {c_h_f[23:0], 8'd0};
      c_px_r   <= b_px_r;
      c_py_r   <= b_py_r;
      c_dx_r   <= b_dx_r;
      c_dy_r   <= b_dy_r;
    end
  end

  logic [15:0] s16;
  rsps_isqrt #(.W(rsps_pkg::H_SQ_W)) u_sq_h (
    .clk(clk), .en(en), .rad(c_sqin_r), .root(s16)
  );

  localparam int CAW = 1 + 17 + 17 + 2 * CW;
  logic [CAW-1:0] ca_q;
  rsps_delay #(.W(CAW), .N(rsps_pkg::H_SQ_STEPS)) u_dly_c (
    .clk(clk), .en(en), .d({c_hit_r, c_dx_r, c_dy_r, c_px_r, c_py_r}), .q(ca_q)
  );

  logic               ca_hit;
  logic signed [16:0] ca_dx, ca_dy;
  logic [CW-1:0]      ca_px, ca_py;
  assign {ca_hit, ca_dx, ca_dy, ca_px, ca_py} = ca_q;

  // ---------------- D: depth, normal, light vectors ----------------
  logic signed [20:0] d_t_f;
  logic signed [15:0] d_dep_f;
  logic               d_hit_r;
  logic signed [15:0] d_dep_r;
  logic signed [16:0] d_nx_r, d_ny_r, d_nz_r;
  logic signed [20:0] d_lx_r [2];
  logic signed [20:0] d_ly_r [2];
  logic signed [21:0] d_lz_r [2];
  logic signed [16:0] d_ldx_f [2];
  logic signed [16:0] d_ldy_f [2];
  logic signed [21:0] d_lz_f  [2];

  always_comb begin
    d_t_f = {cz_r[15], cz_r, 4'd0} - {5'd0, s16};
    if (d_t_f > 21'sd32767) begin
      d_dep_f = 16'sh7FFF;
    end else if (d_t_f < -21'sd32768) begin
      d_dep_f = 16'sh8000;
    end else begin
      d_dep_f = d_t_f[15:0];
    end
    for (int j = 0; j < 2; j++) begin
      d_ldx_f[j] = {lp_r[j][15], lp_r[j][15:0]} - {{(17-CW){1'b0}}, ca_px};
      d_ldy_f[j] = {lp_r[j][31], lp_r[j][31:16]} - {{(17-CW){1'b0}}, ca_py};
      d_lz_f[j]  = {{2{lp_r[j][47]}}, lp_r[j][47:32], 4'd0} - {d_t_f[20], d_t_f};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_hit_r <= ca_hit;
      d_dep_r <= d_dep_f;
      d_nx_r  <= {ca_dx[12:0], 4'd0};
      d_ny_r  <= {ca_dy[12:0], 4'd0};
      d_nz_r  <= 17'd0 - {1'b0, s16};
      for (int j = 0; j < 2; j++) begin
        d_lx_r[j] <= {d_ldx_f[j], 4'd0};
        d_ly_r[j] <= {d_ldy_f[j], 4'd0};
        d_lz_r[j] <= d_lz_f[j];
      end
    end
  end

  logic [16:0] hd_q;
  rsps_delay #(.W(17), .N(40)) u_dly_hd (
    .clk(clk), .en(en), .d({d_hit_r, d_dep_r}), .q(hd_q)
  );

  // ---------------- E: squares and dot-product terms ----------------
  logic signed [33:0] e_nx2_f, e_ny2_f, e_nz2_f;
  logic signed [41:0] e_lx2_f [2];
  logic signed [41:0] e_ly2_f [2];
  logic signed [43:0] e_lz2_f [2];
  logic signed [37:0] e_pxn_f [2];
  logic signed [37:0] e_pyn_f [2];
  logic signed [38:0] e_pzn_f [2];
  logic        [31:0] e_nx2_r, e_ny2_r, e_nz2_r;
  logic        [39:0] e_lx2_r [2];
  logic        [39:0] e_ly2_r [2];
  logic        [40:0] e_lz2_r [2];
  logic signed [38:0] e_pxn_r [2];
  logic signed [38:0] e_pyn_r [2];
  logic signed [38:0] e_pzn_r [2];

  always_comb begin
    e_nx2_f = 34'(d_nx_r) * 34'(d_nx_r);
    e_ny2_f = 34'(d_ny_r) * 34'(d_ny_r);
    e_nz2_f = 34'(d_nz_r) * 34'(d_nz_r);
    for (int j = 0; j < 2; j++) begin
      e_lx2_f[j] = 42'(d_lx_r[j]) * 42'(d_lx_r[j]);
      e_ly2_f[j] = 42'(d_ly_r[j]) * 42'(d_ly_r[j]);
      e_lz2_f[j] = 44'(d_lz_r[j]) * 44'(d_lz_r[j]);
      e_pxn_f[j] = 38'(d_lx_r[j]) * 38'(d_nx_r);
      e_pyn_f[j] = 38'(d_ly_r[j]) * 38'(d_ny_r);
      e_pzn_f[j] = 39'(d_lz_r[j]) * 39'(d_nz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_nx2_r <= e_nx2_f[31:0];
      e_ny2_r <= e_ny2_f[31:0];
      e_nz2_r <= e_nz2_f[31:0];
      for (int j = 0; j < 2; j++) begin
        e_lx2_r[j] <= e_lx2_f[j][39:0];
        e_ly2_r[j] <= e_ly2_f[j][39:0];
        e_lz2_r[j] <= e_lz2_f[j][40:0];
        e_pxn_r[j] <= {e_pxn_f[j][37], e_pxn_f[j]};
        e_pyn_r[j] <= {e_pyn_f[j][37], e_pyn_f[j]};
        e_pzn_r[j] <= e_pzn_f[j];
      end
    end
  end

  // ---------------- F: sums ----------------
  logic        [31:0] f_nn_r;
  logic        [41:0] f_ll_r [2];
  logic signed [38:0] f_dd_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      f_nn_r <= e_nx2_r + e_ny2_r + e_nz2_r;
      for (int j = 0; j < 2; j++) begin
        f_ll_r[j] <= {2'd0, e_lx2_r[j]} + {2'd0, e_ly2_r[j]} + {1'b0, e_lz2_r[j]};
        f_dd_r[j] <= e_pxn_r[j] + e_pyn_r[j] + e_pzn_r[j];
      end
    end
  end

  logic [20:0] nlen_f, llen0, llen1;
  rsps_isqrt #(.W(rsps_pkg::L_SQ_W)) u_sq_n (
    .clk(clk), .en(en), .rad({10'd0, f_nn_r}), .root(nlen_f)
  );
  rsps_isqrt #(.W(rsps_pkg::L_SQ_W)) u_sq_l0 (
    .clk(clk), .en(en), .rad(f_ll_r[0]), .root(llen0)
  );
  rsps_isqrt #(.W(rsps_pkg::L_SQ_W)) u_sq_l1 (
    .clk(clk), .en(en), .rad(f_ll_r[1]), .root(llen1)
  );

  logic [77:0] dd_q;
  rsps_delay #(.W(78), .N(rsps_pkg::L_SQ_STEPS)) u_dly_dd (
    .clk(clk), .en(en), .d({f_dd_r[1], f_dd_r[0]}), .q(dd_q)
  );

  // ---------------- G: denominators and magnitudes ----------------
  logic signed [38:0] g_dd_f [2];
  logic        [38:0] g_mag_f [2];
  logic        [20:0] g_llen_f [2];
  logic        [36:0] g_den_r [2];
  logic        [37:0] g_ad_r  [2];
  logic               g_neg_r [2];

  assign g_dd_f[0]   = dd_q[38:0];
  assign g_dd_f[1]   = dd_q[77:39];
  assign g_llen_f[0] = llen0;
  assign g_llen_f[1] = llen1;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      g_mag_f[j] = g_dd_f[j][38] ? (39'd0 - g_dd_f[j]) : g_dd_f[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        g_den_r[j] <= 37'(g_llen_f[j]) * 37'(nlen_f[15:0]);
        g_ad_r[j]  <= g_mag_f[j][37:0];
        g_neg_r[j] <= g_dd_f[j][38];
      end
    end
  end

  // ---------------- H: overflow check, divider setup ----------------
  logic [36:0] h_rem_r [2];
  logic [36:0] h_den_r [2];
  rsps_pkg::rsps_cos_flags_t h_fl_r [2];
  logic        h_ovf_f [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      h_ovf_f[j] = g_ad_r[j] >= {1'b0, g_den_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        h_rem_r[j]     <= h_ovf_f[j] ? 37'd0 : g_ad_r[j][36:0];
        h_den_r[j]     <= g_den_r[j];
        h_fl_r[j].ovf  <= h_ovf_f[j];
        h_fl_r[j].zero <= g_den_r[j] == 37'd0;
        h_fl_r[j].neg  <= g_neg_r[j];
      end
    end
  end

  logic [14:0] quo [2];
  rsps_div #(.RW(rsps_pkg::DIV_RW), .QW(rsps_pkg::DIV_STEPS)) u_div0 (
    .clk(clk), .en(en), .rem_in(h_rem_r[0]), .den_in(h_den_r[0]), .quo(quo[0])
  );
  rsps_div #(.RW(rsps_pkg::DIV_RW), .QW(rsps_pkg::DIV_STEPS)) u_div1 (
    .clk(clk), .en(en), .rem_in(h_rem_r[1]), .den_in(h_den_r[1]), .quo(quo[1])
  );

  rsps_pkg::rsps_cos_flags_t fl_q [2];
  logic [5:0] fl_dq;
  rsps_delay #(.W(6), .N(rsps_pkg::DIV_STEPS)) u_dly_fl (
    .clk(clk), .en(en), .d({h_fl_r[1], h_fl_r[0]}), .q(fl_dq)
  );
  assign fl_q[0] = fl_dq[2:0];
  assign fl_q[1] = fl_dq[5:3];

  // ---------------- I: cosines and their sum ----------------
  logic signed [15:0] i_cos_f [2];
  logic signed [16:0] i_s_r;
  logic               i_hit_r;
  logic signed [15:0] i_dep_r;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (fl_q[j].zero) begin
        i_cos_f[j] = 16'sd0;
      end else if (fl_q[j].ovf) begin
        i_cos_f[j] = fl_q[j].neg ? 16'sh8000 : 16'sh7FFF;
      end else if (fl_q[j].neg) begin
        i_cos_f[j] = 16'd0 - {1'b0, quo[j]};
      end else begin
        i_cos_f[j] = {1'b0, quo[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_s_r   <= {i_cos_f[0][15], i_cos_f[0]} + {i_cos_f[1][15], i_cos_f[1]};
      i_hit_r <= hd_q[16];
      i_dep_r <= hd_q[15:0];
    end
  end

  // ---------------- O: color levels, output register ----------------
  function automatic logic [7:0] level(input logic signed [27:0] num);
    logic signed [27:0] v;
    v = num >>> 17;
    if (num < 0) begin
      return 8'd0;
    end else if (v > 28'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  logic signed [27:0] o_gn_f, o_rn_f, o_s_f;
  logic               o_hit_r;
  logic signed [15:0] o_dep_r;
  logic        [7:0]  o_red_r, o_grn_r;

  always_comb begin
    o_s_f  = 28'(i_s_r);
    o_gn_f = o_s_f * 28'sd765;
    o_rn_f = o_gn_f + 28'sd16711680;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit_r <= i_hit_r;
      o_dep_r <= i_hit_r ? i_dep_r : 16'sd0;
      o_red_r <= i_hit_r ? level(o_rn_f) : 8'd0;
      o_grn_r <= i_hit_r ? level(o_gn_f) : 8'd0;
    end
  end

  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.hit         = o_hit_r;
  assign out_ch.hit_depth   = o_dep_r;
  assign out_ch.red_level   = o_red_r;
  assign out_ch.green_level = o_grn_r;
  assign out_ch.blue_level  = o_grn_r;

  // ---------------- assertions ----------------
  a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |-> out_ch.red_level == 8'd0 &&
      out_ch.green_level == 8'd0 && out_ch.hit_depth == 16'sd0)
    else $error("miss result is not black");

  a_red_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> out_ch.red_level >= out_ch.green_level)
    else $error("red level below green level on a hit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_ready_en: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while the output is stalled");

endmodule
`default_nettype wire
